// ===== rtl/core/isapid_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isapid_pkg
// Shared types, constants and the control program of the incremental PID core.
// ----------------------------------------------------------------------------
package isapid_pkg;

  // Data formats
  localparam int DW  = 32;            // signal width, Q16.16
  localparam int FB  = 16;            // fraction bits
  localparam int GW  = 31;            // gain register width
  localparam int WW  = 17;            // weight / pole register width
  localparam int DFW = DW + 1;        // width of a difference of two samples
  localparam int MAW = DW + 4;        // multiplier signed operand width
  localparam int PW  = MAW + GW + 1;  // full product width
  localparam int ACW = PW - FB;       // scaled product and accumulator width

  localparam logic signed [DW-1:0] DATA_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DATA_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [GW-1:0]        ONE_GAIN = GW'(1) << FB;
  localparam logic [WW-1:0]        ONE_WGT  = WW'(1) << FB;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN       = 3'd0,
    CFG_INTEGRAL_GAIN   = 3'd1,
    CFG_DERIV_POLE      = 3'd2,
    CFG_DERIV_GAIN      = 3'd3,
    CFG_PROP_SP_WEIGHT  = 3'd4,
    CFG_DERIV_SP_WEIGHT = 3'd5,
    CFG_OUT_MAX         = 3'd6,
    CFG_OUT_MIN         = 3'd7
  } cfg_idx_e_t;

  typedef struct packed {
    logic [GW-1:0]        prop_gain;
    logic [GW-1:0]        integral_gain;
    logic [WW-1:0]        deriv_pole;
    logic [GW-1:0]        deriv_gain;
    logic [WW-1:0]        prop_sp_weight;
    logic [WW-1:0]        deriv_sp_weight;
    logic signed [DW-1:0] out_max;
    logic signed [DW-1:0] out_min;
  } cfg_t;

  // Request and result payloads
  typedef struct packed {
    logic signed [DW-1:0] setpoint;
    logic signed [DW-1:0] measurement;
    logic signed [DW-1:0] track_value;
    logic                 track_mode;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] control;
    logic                 hit_high;
    logic                 hit_low;
  } out_item_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  // Control word fields
  typedef enum logic [1:0] {
    MA_DSP,
    MA_TMP,
    MA_ERR,
    MA_LASTD
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_PWEIGHT,
    MB_PGAIN,
    MB_IGAIN,
    MB_DWEIGHT,
    MB_DGAIN,
    MB_DPOLE
  } mul_b_t;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_LOAD,
    ALU_TMP,
    ALU_ACC_PROD,
    ALU_DSET,
    ALU_DADD,
    ALU_ACC_D,
    ALU_TRACK,
    ALU_FINISH
  } alu_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_BR_TRACK,
    SEQ_GOTO,
    SEQ_END
  } seq_op_t;

  localparam int STEP_W      = 4;
  localparam int UCODE_DEPTH = 1 << STEP_W;

  localparam logic [STEP_W-1:0] STEP_FINISH = 4'd14;
  localparam logic [STEP_W-1:0] STEP_TRACK  = 4'd15;
  localparam logic [STEP_W-1:0] STEP_NONE   = 4'd0;

  typedef struct packed {
    logic              mul_en;
    mul_a_t            mul_a;
    mul_b_t            mul_b;
    alu_op_t           alu;
    seq_op_t           seq;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Control program, one word per step
  localparam ucode_t UCODE [UCODE_DEPTH] = '{
    // latch differences, seed acc with last output minus last derivative
    '{1'b0, MA_DSP,   MB_PWEIGHT, ALU_LOAD,     SEQ_BR_TRACK, STEP_TRACK},
    // proportional increment: K * (b*dsp - dpv)
    '{1'b1, MA_DSP,   MB_PWEIGHT, ALU_NOP,      SEQ_NEXT,     STEP_NONE},
    '{1'b0, MA_DSP,   MB_PWEIGHT, ALU_TMP,      SEQ_NEXT,     STEP_NONE},
    '{1'b1, MA_TMP,   MB_PGAIN,   ALU_NOP,      SEQ_NEXT,     STEP_NONE},
    '{1'b0, MA_DSP,   MB_PWEIGHT, ALU_ACC_PROD, SEQ_NEXT,     STEP_NONE},
    // integral increment: Ki * (sp - pv)
    '{1'b1, MA_ERR,   MB_IGAIN,   ALU_NOP,      SEQ_NEXT,     STEP_NONE},
    '{1'b0, MA_DSP,   MB_PWEIGHT, ALU_ACC_PROD, SEQ_NEXT,     STEP_NONE},
    // filtered derivative: a*Dold + g*(c*dsp - dpv)
    '{1'b1, MA_DSP,   MB_DWEIGHT, ALU_NOP,      SEQ_NEXT,     STEP_NONE},
    '{1'b0, MA_DSP,   MB_PWEIGHT, ALU_TMP,      SEQ_NEXT,     STEP_NONE},
    '{1'b1, MA_TMP,   MB_DGAIN,   ALU_NOP,      SEQ_NEXT,     STEP_NONE},
    '{1'b0, MA_DSP,   MB_PWEIGHT, ALU_DSET,     SEQ_NEXT,     STEP_NONE},
    '{1'b1, MA_LASTD, MB_DPOLE,   ALU_NOP,      SEQ_NEXT,     STEP_NONE},
    '{1'b0, MA_DSP,   MB_PWEIGHT, ALU_DADD,     SEQ_NEXT,     STEP_NONE},
    '{1'b0, MA_DSP,   MB_PWEIGHT, ALU_ACC_D,    SEQ_NEXT,     STEP_NONE},
    // clamp, store state, hand off result
    '{1'b0, MA_DSP,   MB_PWEIGHT, ALU_FINISH,   SEQ_END,      STEP_NONE},
    // tracking path
    '{1'b0, MA_DSP,   MB_PWEIGHT, ALU_TRACK,    SEQ_GOTO,     STEP_FINISH}
  };

endpackage
`default_nettype wire

// ===== rtl/core/isapid_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isapid_datapath
// Shared multiplier, accumulator, controller state and output clamp, driven
// one control word per cycle by the sequencer while exec is high.
// ----------------------------------------------------------------------------
module isapid_datapath import isapid_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      exec,
  input  wire ucode_t    uc,
  input  wire cfg_t      cfg,
  input  wire in_item_t  item,
  output out_item_t      result
);

  // Controller state
  logic signed [DW-1:0]  last_sp_r;
  logic signed [DW-1:0]  last_pv_r;
  logic signed [DW-1:0]  last_out_r;
  logic signed [DW-1:0]  last_d_r;

  // Working registers
  logic signed [DFW-1:0] dsp_r;
  logic signed [DFW-1:0] dpv_r;
  logic signed [DFW-1:0] err_r;
  logic signed [MAW-1:0] tmp_r;
  logic signed [ACW-1:0] prod_r;
  logic signed [ACW-1:0] acc_r;
  logic signed [ACW-1:0] d_r;

  logic signed [MAW-1:0] mul_a;
  logic [GW-1:0]         mul_b;
  logic signed [PW-1:0]  prod_full;
  logic signed [ACW-1:0] prod_nxt;
  logic signed [ACW-1:0] d_sum;
  logic signed [ACW-1:0] d_sat;
  logic signed [ACW-1:0] lim_hi;
  logic signed [ACW-1:0] lim_lo;
  logic signed [ACW-1:0] clip_hi;
  logic signed [ACW-1:0] clip_out;
  logic                  hit_hi;
  logic                  hit_lo;

  // Select multiplier operands
  always_comb begin
    case (uc.mul_a)
      MA_DSP:   mul_a = MAW'(dsp_r);
      MA_TMP:   mul_a = tmp_r;
      MA_ERR:   mul_a = MAW'(err_r);
      MA_LASTD: mul_a = MAW'(last_d_r);
      default:  mul_a = '0;
    endcase
  end

  always_comb begin
    case (uc.mul_b)
      MB_PWEIGHT: mul_b = GW'(cfg.prop_sp_weight);
      MB_PGAIN:   mul_b = cfg.prop_gain;
      MB_IGAIN:   mul_b = cfg.integral_gain;
      MB_DWEIGHT: mul_b = GW'(cfg.deriv_sp_weight);
      MB_DGAIN:   mul_b = cfg.deriv_gain;
      MB_DPOLE:   mul_b = GW'(cfg.deriv_pole);
      default:    mul_b = '0;
    endcase
  end

  // Signed times unsigned, floor-scaled by dropping the fraction bits
  assign prod_full = mul_a * $signed({1'b0, mul_b});
  assign prod_nxt  = prod_full[FB +: ACW];

  // Saturate the new derivative to the signal range
  assign d_sum = d_r + prod_r;
  always_comb begin
    if (d_sum > ACW'(DATA_MAX)) begin
      d_sat = ACW'(DATA_MAX);
    end else if (d_sum < ACW'(DATA_MIN)) begin
      d_sat = ACW'(DATA_MIN);
    end else begin
      d_sat = d_sum;
    end
  end

  // Clamp at the maximum first, then at the minimum
  assign lim_hi   = ACW'($signed(cfg.out_max));
  assign lim_lo   = ACW'($signed(cfg.out_min));
  assign hit_hi   = acc_r > lim_hi;
  assign clip_hi  = hit_hi ? lim_hi : acc_r;
  assign hit_lo   = clip_hi < lim_lo;
  assign clip_out = hit_lo ? lim_lo : clip_hi;

  assign result.control  = clip_out[DW-1:0];
  assign result.hit_high = hit_hi;
  assign result.hit_low  = hit_lo;

  // Update controller state at the end of each request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sp_r  <= '0;
      last_pv_r  <= '0;
      last_out_r <= '0;
      last_d_r   <= '0;
    end else if (exec && uc.alu == ALU_FINISH) begin
      last_sp_r  <= item.setpoint;
      last_pv_r  <= item.measurement;
      last_out_r <= clip_out[DW-1:0];
      last_d_r   <= d_r[DW-1:0];
    end
  end

  // Execute the current control word
  always_ff @(posedge clk) begin
    if (exec) begin
      if (uc.mul_en) begin
        prod_r <= prod_nxt;
      end
      case (uc.alu)
        ALU_LOAD: begin
          dsp_r <= DFW'($signed(item.setpoint)) - DFW'(last_sp_r);
          dpv_r <= DFW'($signed(item.measurement)) - DFW'(last_pv_r);
          err_r <= DFW'($signed(item.setpoint)) - DFW'($signed(item.measurement));
          acc_r <= ACW'(last_out_r) - ACW'(last_d_r);
        end
        ALU_TMP: begin
          tmp_r <= MAW'(prod_r - ACW'(dpv_r));
        end
        ALU_ACC_PROD: begin
          acc_r <= acc_r + prod_r;
        end
        ALU_DSET: begin
          d_r <= prod_r;
        end
        ALU_DADD: begin
          d_r <= d_sat;
        end
        ALU_ACC_D: begin
          acc_r <= acc_r + d_r;
        end
        ALU_TRACK: begin
          acc_r <= ACW'($signed(item.track_value));
          d_r   <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/isa_pid_incremental_controller_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isa_pid_incremental_controller_core
// Velocity-form PID controller, Q16.16, with output tracking and clamping.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per control sample (setpoint, measurement, tracking
//           value, tracking flag). in_ready is high while no request is
//           being computed.
//   out_* : one result per request (control value and clamp flags), held in
//           an output register until taken.
//   cfg_* : register writes, always ready; write only while idle.
// Program: a request runs through a 16-word control program on one shared
//   36x32 multiplier; an automatic sample runs 15 steps and a tracking
//   sample runs 3 steps. The next request is accepted only once the
//   previous one has left its final step.
// A new request is accepted while the previous result still waits; if the
//   receiver still stalls when the next result is ready, the program holds
//   on its final step until the output register frees up.
// Reset restores the default gains and limits and clears the stored
//   setpoint, measurement, output and derivative.
// ----------------------------------------------------------------------------
module isa_pid_incremental_controller_core import isapid_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DW-1:0]        cfg_data
);

  seq_state_t        state_r;
  seq_state_t        state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  in_item_t          item_r;
  cfg_t              cfg_r;
  logic              out_valid_r;
  out_item_t         out_data_r;
  out_item_t         result;
  ucode_t            uc;
  logic              in_accept;
  logic              exec;
  logic              done;

  assign uc        = UCODE[step_r];
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_RUN;
      ST_RUN:  if (done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: hold on the final step while the result slot is full
  always_comb begin
    in_ready = 1'b0;
    exec     = 1'b0;
    done     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_RUN: begin
        exec = !(uc.alu == ALU_FINISH && out_valid_r && !out_ready);
        done = exec && uc.alu == ALU_FINISH;
      end
      default: begin
      end
    endcase
  end

  // Advance the step counter
  always_comb begin
    step_nxt = step_r;
    if (in_accept) begin
      step_nxt = '0;
    end else if (exec) begin
      case (uc.seq)
        SEQ_NEXT:     step_nxt = step_r + 1'b1;
        SEQ_BR_TRACK: step_nxt = item_r.track_mode ? uc.target : step_r + 1'b1;
        SEQ_GOTO:     step_nxt = uc.target;
        SEQ_END:      step_nxt = step_r;
        default:      step_nxt = step_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Latch the request and the result
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
    if (done) begin
      out_data_r <= result;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain       <= ONE_GAIN;
      cfg_r.integral_gain   <= '0;
      cfg_r.deriv_pole      <= '0;
      cfg_r.deriv_gain      <= '0;
      cfg_r.prop_sp_weight  <= ONE_WGT;
      cfg_r.deriv_sp_weight <= '0;
      cfg_r.out_max         <= DATA_MAX;
      cfg_r.out_min         <= DATA_MIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_e_t'(cfg_index))
        CFG_PROP_GAIN:       cfg_r.prop_gain       <= cfg_data[GW-1:0];
        CFG_INTEGRAL_GAIN:   cfg_r.integral_gain   <= cfg_data[GW-1:0];
        CFG_DERIV_POLE:      cfg_r.deriv_pole      <= cfg_data[WW-1:0];
        CFG_DERIV_GAIN:      cfg_r.deriv_gain      <= cfg_data[GW-1:0];
        CFG_PROP_SP_WEIGHT:  cfg_r.prop_sp_weight  <= cfg_data[WW-1:0];
        CFG_DERIV_SP_WEIGHT: cfg_r.deriv_sp_weight <= cfg_data[WW-1:0];
        CFG_OUT_MAX:         cfg_r.out_max         <= cfg_data;
        CFG_OUT_MIN:         cfg_r.out_min         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  isapid_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .exec   (exec),
    .uc     (uc),
    .cfg    (cfg_r),
    .item   (item_r),
    .result (result)
  );

endmodule
`default_nettype wire

// ===== tb/isa_pid_incremental_controller_core_tb.sv =====
// ----------------------------------------------------------------------------
// isa_pid_incremental_controller_core_tb
// Self-checking regression for the velocity-form PID core. Requests are
// driven over the valid/ready input channel and each result is compared
// against a bit-exact Q16.16 predictor kept in step with the register file.
// Directed requests hit the field extremes, the clamps, crossed limits,
// tracking and masked coefficients. Random phases then run drifting
// operating points and noise under many tunings, with random stalls on both
// sides and one long output hold.
// ----------------------------------------------------------------------------
module isa_pid_incremental_controller_core_tb import isapid_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CYCLE_LIMIT  = 500_000;
  localparam int     DRAIN_CYCLES = 24;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     Q1           = 1 << FB;
  localparam longint WIDE_LIM     = 64'sd1 << 61;
  localparam longint SIG_MAX      = DATA_MAX;
  localparam longint SIG_MIN      = DATA_MIN;
  localparam longint PATH_LIM     = 64'sd1000 * Q1;

  // Raw register values as written; the core masks them to their widths
  typedef struct packed {
    logic [31:0] prop_gain;
    logic [31:0] integral_gain;
    logic [31:0] deriv_pole;
    logic [31:0] deriv_gain;
    logic [31:0] prop_sp_weight;
    logic [31:0] deriv_sp_weight;
    logic [31:0] out_max;
    logic [31:0] out_min;
  } tuning_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DW-1:0]        cfg_data  = '0;

  // Predictor state: register mirror and stored loop history
  cfg_t      gains;
  longint    prev_sp, prev_pv, prev_ctl, prev_deriv;
  out_item_t control_q[$];
  longint    path_sp, path_pv;

  bit pace_idle    = 1'b1;
  int stall_orders = 0;
  int stall_served = 0;
  int hold_left    = 0;
  int cycle_count  = 0;

  int samples_sent, tracking_sent, high_clamps, low_clamps;
  int tunings_loaded, controls_checked, mismatches;

  isa_pid_incremental_controller_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("isa_pid_incremental_controller_core regression: fail");
      $finish;
    end
  end

  // Drive out_ready: sparse random stalls, long holds when ordered
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_served != stall_orders) begin
      out_ready    <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      stall_served <= stall_served + 1;
    end else begin
      out_ready <= !(pace_idle && $urandom_range(99) < 10);
    end
  end

  // Compare each accepted result with the oldest predicted control
  always @(posedge clk) begin : check_controls
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (control_q.size() == 0) begin
        $error("result with nothing expected: control %0d", $signed(out_data.control));
        mismatches++;
      end else begin
        want = control_q.pop_front();
        controls_checked++;
        if (out_data.control !== want.control) begin
          $error("control: expected %0d, got %0d", $signed(want.control),
                 $signed(out_data.control));
          mismatches++;
        end
        if (out_data.hit_high !== want.hit_high) begin
          $error("hit_high: expected %0b, got %0b", want.hit_high, out_data.hit_high);
          mismatches++;
        end
        if (out_data.hit_low !== want.hit_low) begin
          $error("hit_low: expected %0b, got %0b", want.hit_low, out_data.hit_low);
          mismatches++;
        end
      end
    end
  end

  // Saturate a wide intermediate at +-2^61
  function automatic longint wide_sat(input longint v);
    if (v > WIDE_LIM) return WIDE_LIM;
    if (v < -WIDE_LIM) return -WIDE_LIM;
    return v;
  endfunction

  // floor(x * coef / 2^FB), exact product, saturated like the wide sums
  function automatic longint q_mul(input longint x, input logic [GW-1:0] coef);
    logic signed [127:0] xs, cs, prod;
    xs   = x;
    cs   = {97'b0, coef};
    prod = (xs * cs) >>> FB;
    if (prod > WIDE_LIM) return WIDE_LIM;
    if (prod < -WIDE_LIM) return -WIDE_LIM;
    return longint'(prod);
  endfunction

  // Predict the control result of one sample and advance the loop history
  function automatic out_item_t next_control(input in_item_t s);
    longint    sp, pv, dsp, dpv, dp, di, dnew, ctl, hi, lo;
    out_item_t r;
    r  = '0;
    sp = $signed(s.setpoint);
    pv = $signed(s.measurement);
    hi = $signed(gains.out_max);
    lo = $signed(gains.out_min);
    if (s.track_mode) begin
      // follow the tracking value, drop the derivative history
      ctl  = $signed(s.track_value);
      dnew = 0;
    end else begin
      dsp  = sp - prev_sp;
      dpv  = pv - prev_pv;
      dp   = q_mul(wide_sat(q_mul(dsp, gains.prop_sp_weight) - dpv), gains.prop_gain);
      di   = q_mul(sp - pv, gains.integral_gain);
      dnew = wide_sat(q_mul(prev_deriv, gains.deriv_pole) +
                      q_mul(wide_sat(q_mul(dsp, gains.deriv_sp_weight) - dpv),
                            gains.deriv_gain));
      if (dnew > SIG_MAX) dnew = SIG_MAX;
      if (dnew < SIG_MIN) dnew = SIG_MIN;
      ctl = wide_sat(prev_ctl + dp);
      ctl = wide_sat(ctl + di);
      ctl = wide_sat(ctl + (dnew - prev_deriv));
    end
    // max clamp first, so the min clamp wins on crossed limits
    if (ctl > hi) begin
      ctl        = hi;
      r.hit_high = 1'b1;
    end
    if (ctl < lo) begin
      ctl       = lo;
      r.hit_low = 1'b1;
    end
    prev_sp    = sp;
    prev_pv    = pv;
    prev_ctl   = ctl;
    prev_deriv = dnew;
    r.control  = ctl[DW-1:0];
    return r;
  endfunction

  function automatic in_item_t make_sample(input logic [31:0] sp, pv, tv,
                                           input logic tm);
    in_item_t s;
    s.setpoint    = sp;
    s.measurement = pv;
    s.track_value = tv;
    s.track_mode  = tm;
    return s;
  endfunction

  function automatic tuning_t make_tuning(input logic [31:0] k, ki, a, g, b, c,
                                          hi, lo);
    tuning_t t;
    t = '{k, ki, a, g, b, c, hi, lo};
    return t;
  endfunction

  // Random tuning: moderate loop gains, or raw 32-bit register noise
  function automatic tuning_t random_tuning(input bit wild);
    tuning_t t;
    int      hi, lo, tmp;
    if (wild) begin
      t = '{$urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), $urandom()};
    end else begin
      hi = $urandom_range(0, 600 * Q1) - 300 * Q1;
      lo = $urandom_range(0, 600 * Q1) - 300 * Q1;
      // keep limits ordered except for an occasional crossed pair
      if (hi < lo && $urandom_range(99) >= 15) begin
        tmp = hi;
        hi  = lo;
        lo  = tmp;
      end
      t = make_tuning($urandom_range(0, 4 * Q1), $urandom_range(0, Q1),
                      $urandom_range(0, Q1), $urandom_range(0, 8 * Q1),
                      $urandom_range(0, Q1), $urandom_range(0, Q1), hi, lo);
    end
    return t;
  endfunction

  // Drifting operating point: setpoint walks and jumps, measurement follows
  function automatic in_item_t path_sample();
    in_item_t s;
    if ($urandom_range(99) < 5)
      path_sp = longint'($urandom_range(0, 2000 * Q1)) - PATH_LIM;
    else
      path_sp += longint'($urandom_range(0, 4 * Q1)) - 2 * Q1;
    path_pv += (path_sp - path_pv) / 8 + longint'($urandom_range(0, Q1)) - Q1 / 2;
    if (path_sp > PATH_LIM) path_sp = PATH_LIM;
    if (path_sp < -PATH_LIM) path_sp = -PATH_LIM;
    if (path_pv > PATH_LIM) path_pv = PATH_LIM;
    if (path_pv < -PATH_LIM) path_pv = -PATH_LIM;
    s.setpoint    = path_sp[31:0];
    s.measurement = path_pv[31:0];
    s.track_mode  = $urandom_range(99) < 8;
    s.track_value = $urandom_range(3) == 0 ? $urandom() : path_pv[31:0];
    return s;
  endfunction

  function automatic in_item_t mixed_sample();
    in_item_t s;
    if ($urandom_range(99) < 12)
      s = make_sample($urandom(), $urandom(), $urandom(), 1'($urandom_range(1)));
    else
      s = path_sample();
    return s;
  endfunction

  // Offer one request, hold it until accepted, then queue its prediction
  task automatic send_sample(input in_item_t s);
    out_item_t want;
    if (pace_idle && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 40) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = next_control(s);
    control_q.push_back(want);
    samples_sent++;
    if (s.track_mode) tracking_sent++;
    if (want.hit_high) high_clamps++;
    if (want.hit_low) low_clamps++;
  endtask

  // Stop offering and wait until every predicted result has been taken
  task automatic drain_controls();
    in_valid <= 1'b0;
    do @(posedge clk); while (control_q.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_e_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PROP_GAIN:       gains.prop_gain       = value[GW-1:0];
      CFG_INTEGRAL_GAIN:   gains.integral_gain   = value[GW-1:0];
      CFG_DERIV_POLE:      gains.deriv_pole      = value[WW-1:0];
      CFG_DERIV_GAIN:      gains.deriv_gain      = value[GW-1:0];
      CFG_PROP_SP_WEIGHT:  gains.prop_sp_weight  = value[WW-1:0];
      CFG_DERIV_SP_WEIGHT: gains.deriv_sp_weight = value[WW-1:0];
      CFG_OUT_MAX:         gains.out_max         = value;
      CFG_OUT_MIN:         gains.out_min         = value;
      default: ;
    endcase
  endtask

  // Write the whole register file back to back
  task automatic load_tuning(input tuning_t t);
    write_reg(CFG_PROP_GAIN, t.prop_gain);
    write_reg(CFG_INTEGRAL_GAIN, t.integral_gain);
    write_reg(CFG_DERIV_POLE, t.deriv_pole);
    write_reg(CFG_DERIV_GAIN, t.deriv_gain);
    write_reg(CFG_PROP_SP_WEIGHT, t.prop_sp_weight);
    write_reg(CFG_DERIV_SP_WEIGHT, t.deriv_sp_weight);
    write_reg(CFG_OUT_MAX, t.out_max);
    write_reg(CFG_OUT_MIN, t.out_min);
    cfg_valid <= 1'b0;
    tunings_loaded++;
  endtask

  // Default gains: full-scale steps, tracking at both extremes
  task automatic test_reset_tuning();
    send_sample(make_sample(0, 0, 0, 1'b0));
    send_sample(make_sample(DATA_MAX, DATA_MIN, 0, 1'b0));
    send_sample(make_sample(DATA_MIN, DATA_MAX, 0, 1'b0));
    send_sample(make_sample(Q1, 0, DATA_MAX, 1'b1));
    send_sample(make_sample(0, 0, DATA_MIN, 1'b1));
  endtask

  // All-ones gain, pole and weight registers (masked gains, pole and weights above one), then all zero
  task automatic test_extreme_tunings();
    drain_controls();
    load_tuning(make_tuning('1, '1, '1, '1, '1, '1, DATA_MAX, DATA_MIN));
    send_sample(make_sample(DATA_MAX, DATA_MIN, 0, 1'b0));
    send_sample(make_sample(DATA_MIN, DATA_MAX, 0, 1'b0));
    send_sample(make_sample(0, 0, 0, 1'b0));
    // one-LSB steps check floor rounding of negative products
    send_sample(make_sample(-1, 0, 0, 1'b0));
    send_sample(make_sample(0, 1, 0, 1'b0));
    drain_controls();
    load_tuning('0);
    send_sample(make_sample(0, 0, DATA_MAX, 1'b1));
    send_sample(make_sample(0, 0, DATA_MIN, 1'b1));
  endtask

  // Filtered derivative builds up, tracking clamps and clears it
  task automatic test_derivative_and_tracking();
    drain_controls();
    load_tuning(make_tuning(Q1, Q1 / 4, Q1 / 2, 2 * Q1, Q1 / 2, Q1, 10 * Q1, -10 * Q1));
    send_sample(make_sample(Q1, 0, 0, 1'b0));
    send_sample(make_sample(Q1, Q1 / 4, 0, 1'b0));
    send_sample(make_sample(2 * Q1, Q1 / 2, 0, 1'b0));
    send_sample(make_sample(2 * Q1, Q1, 0, 1'b0));
    send_sample(make_sample(2 * Q1, Q1, 20 * Q1, 1'b1));
    send_sample(make_sample(2 * Q1, Q1, -20 * Q1, 1'b1));
    send_sample(make_sample(-Q1, 3 * Q1, 0, 1'b0));
  endtask

  // Maximum below minimum: both clamps act, minimum wins; pole at exactly one
  task automatic test_crossed_limits();
    drain_controls();
    load_tuning(make_tuning(Q1, 0, Q1, Q1, Q1, 0, -5 * Q1, 5 * Q1));
    send_sample(make_sample(0, 0, 0, 1'b1));
    send_sample(make_sample(0, 0, -10 * Q1, 1'b1));
    send_sample(make_sample(3 * Q1, -Q1, 0, 1'b0));
  endtask

  // Phases of random traffic: a default tuning, then alternating raw and moderate tunings, then all-ones gains
  task automatic test_random_tunings();
    tuning_t t;
    for (int phase = 0; phase < 10; phase++) begin
      drain_controls();
      if (phase == 0)
        t = make_tuning(32'(ONE_GAIN), 0, 0, 0, 32'(ONE_WGT), 0, DATA_MAX, DATA_MIN);
      else if (phase == 9)
        t = make_tuning('1, '1, 32'(ONE_WGT), '1, 32'(ONE_WGT), 32'(ONE_WGT),
                        DATA_MAX, DATA_MIN);
      else
        t = random_tuning(phase % 2 == 1);
      load_tuning(t);
      repeat (90) send_sample(mixed_sample());
    end
  endtask

  // Hold the output for a long stretch while requests keep coming
  task automatic test_output_hold();
    pace_idle = 1'b0;
    stall_orders++;
    repeat (60) send_sample(mixed_sample());
    pace_idle = 1'b1;
  endtask

  // Back-to-back requests with both sides always ready
  task automatic test_steady_stream();
    drain_controls();
    load_tuning(random_tuning(1'b0));
    pace_idle = 1'b0;
    repeat (300) send_sample(mixed_sample());
    pace_idle = 1'b1;
  endtask

  initial begin
    // mirror the register file and loop history as reset leaves them
    gains      = '{ONE_GAIN, '0, '0, '0, ONE_WGT, '0, DATA_MAX, DATA_MIN};
    prev_sp    = 0;
    prev_pv    = 0;
    prev_ctl   = 0;
    prev_deriv = 0;
    path_sp    = 0;
    path_pv    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_tuning();
    test_extreme_tunings();
    test_derivative_and_tracking();
    test_crossed_limits();
    test_random_tunings();
    test_output_hold();
    test_steady_stream();

    drain_controls();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d samples (%0d tracking) under %0d tunings, %0d results checked",
             samples_sent, tracking_sent, tunings_loaded, controls_checked);
    $display("outputs clamped: %0d at the maximum, %0d at the minimum",
             high_clamps, low_clamps);
    if (mismatches == 0 && control_q.size() == 0) begin
      $display("isa_pid_incremental_controller_core regression: pass");
    end else begin
      $display("isa_pid_incremental_controller_core regression: fail");
    end
    $finish;
  end

endmodule
